// ===== rtl/core/clca_pkg.sv =====
// Shared types and constants for the color line centroid angle block.
`default_nettype none

package clca_pkg;

   // Field and register widths
   localparam int COLOR_W     = 8;
   localparam int LIMIT_W     = 10;
   localparam int SIZE_W      = 11;
   localparam int VIEW_W      = 15;
   localparam int ANGLE_W     = 15;
   localparam int DIST_W      = 10;
   localparam int CSR_DATA_W  = 15;
   localparam int CSR_INDEX_W = 3;

   // Divider: quotient bits and step counter
   localparam int QUOT_W = 15;
   localparam int STEP_W = 4;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // Register reset values
   localparam logic [COLOR_W-1:0] RST_REF_RED     = 8'd132;
   localparam logic [COLOR_W-1:0] RST_REF_GREEN   = 8'd119;
   localparam logic [COLOR_W-1:0] RST_REF_BLUE    = 8'd48;
   localparam logic [LIMIT_W-1:0] RST_MATCH_LIMIT = 10'd30;
   localparam logic [SIZE_W-1:0]  RST_FRAME_SIZE  = 11'd64;
   localparam logic [VIEW_W-1:0]  RST_VIEW_ANGLE  = 15'd4096;

   // Register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_REF_RED      = 3'd0,
      CSR_REF_GREEN    = 3'd1,
      CSR_REF_BLUE     = 3'd2,
      CSR_MATCH_LIMIT  = 3'd3,
      CSR_FRAME_WIDTH  = 3'd4,
      CSR_FRAME_HEIGHT = 3'd5,
      CSR_VIEW_ANGLE   = 3'd6
   } csr_index_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCALE,
      BK_OFFSET,
      BK_PRODUCT,
      BK_DIVIDE,
      BK_DELIVER
   } back_state_type;

   // Back-end control decode
   typedef struct packed {
      logic pop;
      logic load_job;
      logic div_step;
      logic load_out;
   } back_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/core/clca_front.sv =====
// Front end: configuration registers, pixel classification and frame accumulation.
`default_nettype none

module clca_front #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int WID_W = $clog2(MAX_WIDTH + 1),
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1,
   localparam int HGT_W = $clog2(MAX_HEIGHT + 1),
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   localparam int SUM_W = CNT_W + COL_W
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_red,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_green,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_blue,
   output logic                                   req_stall,
   input  wire logic                              csr_write,
   input  wire logic [clca_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [clca_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                              job_full,
   output logic                                   job_push,
   output logic [SUM_W-1:0]                       job_sum,
   output logic [CNT_W-1:0]                       job_count,
   output logic [WID_W-1:0]                       job_width,
   output logic [clca_pkg::VIEW_W-1:0]            job_view
);
   import clca_pkg::*;

   localparam int RST_W = (int'(RST_FRAME_SIZE) > MAX_WIDTH) ? MAX_WIDTH : int'(RST_FRAME_SIZE);
   localparam int RST_H = (int'(RST_FRAME_SIZE) > MAX_HEIGHT) ? MAX_HEIGHT : int'(RST_FRAME_SIZE);

   logic [COLOR_W-1:0] ref_red_ff, ref_red_in;
   logic [COLOR_W-1:0] ref_green_ff, ref_green_in;
   logic [COLOR_W-1:0] ref_blue_ff, ref_blue_in;
   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [VIEW_W-1:0]  view_ff, view_in;
   logic [WID_W-1:0]   width_ff, width_in;
   logic [HGT_W-1:0]   height_ff, height_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   logic [SIZE_W-1:0]  csr_size;
   logic [WID_W-1:0]   width_clamp;
   logic [HGT_W-1:0]   height_clamp;
   logic               restart;
   logic               accept;
   logic [COLOR_W-1:0] diff_red, diff_green, diff_blue;
   logic [DIST_W-1:0]  color_dist;
   logic               match;
   logic               col_last, row_last, frame_last;
   logic [SUM_W-1:0]   sum_next;
   logic [CNT_W-1:0]   cnt_next;

   // Clamp a written frame size into the supported range
   assign csr_size = csr_data[SIZE_W-1:0];

   always_comb begin
      if (csr_size == '0) begin
         width_clamp = WID_W'(1);
      end else if (int'(csr_size) > MAX_WIDTH) begin
         width_clamp = WID_W'(MAX_WIDTH);
      end else begin
         width_clamp = WID_W'(csr_size);
      end
      if (csr_size == '0) begin
         height_clamp = HGT_W'(1);
      end else if (int'(csr_size) > MAX_HEIGHT) begin
         height_clamp = HGT_W'(MAX_HEIGHT);
      end else begin
         height_clamp = HGT_W'(csr_size);
      end
   end

   // Decode register writes
   always_comb begin
      ref_red_in   = ref_red_ff;
      ref_green_in = ref_green_ff;
      ref_blue_in  = ref_blue_ff;
      limit_in     = limit_ff;
      view_in      = view_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      restart      = 1'b0;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_REF_RED:      ref_red_in   = csr_data[COLOR_W-1:0];
            CSR_REF_GREEN:    ref_green_in = csr_data[COLOR_W-1:0];
            CSR_REF_BLUE:     ref_blue_in  = csr_data[COLOR_W-1:0];
            CSR_MATCH_LIMIT:  limit_in     = csr_data[LIMIT_W-1:0];
            CSR_FRAME_WIDTH: begin
               width_in = width_clamp;
               restart  = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               height_in = height_clamp;
               restart   = 1'b1;
            end
            CSR_VIEW_ANGLE:   view_in      = csr_data[VIEW_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Classify the pixel by its distance from the reference color
   always_comb begin
      diff_red   = (req_red > ref_red_ff) ? req_red - ref_red_ff : ref_red_ff - req_red;
      diff_green = (req_green > ref_green_ff) ? req_green - ref_green_ff
                                              : ref_green_ff - req_green;
      diff_blue  = (req_blue > ref_blue_ff) ? req_blue - ref_blue_ff : ref_blue_ff - req_blue;
      color_dist = DIST_W'(diff_red) + DIST_W'(diff_green) + DIST_W'(diff_blue);
      match      = (color_dist < limit_ff);
   end

   // Hold off requests while the job queue is full
   assign req_stall = job_full;
   assign accept    = req_valid && !job_full;

   // Track the raster position
   assign col_last   = (WID_W'(col_ff) == width_ff - WID_W'(1));
   assign row_last   = (HGT_W'(row_ff) == height_ff - HGT_W'(1));
   assign frame_last = col_last && row_last;

   assign sum_next = sum_ff + (match ? SUM_W'(col_ff) : '0);
   assign cnt_next = cnt_ff + CNT_W'(match);

   // Advance the accumulators; restart on a size change or at frame end
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      sum_in = sum_ff;
      cnt_in = cnt_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
         sum_in = '0;
         cnt_in = '0;
      end else if (accept) begin
         if (frame_last) begin
            col_in = '0;
            row_in = '0;
            sum_in = '0;
            cnt_in = '0;
         end else begin
            sum_in = sum_next;
            cnt_in = cnt_next;
            if (col_last) begin
               col_in = '0;
               row_in = row_ff + ROW_W'(1);
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
      end
   end

   // Hand the finished frame to the back end
   assign job_push  = accept && frame_last && !restart;
   assign job_sum   = sum_next;
   assign job_count = cnt_next;
   assign job_width = width_ff;
   assign job_view  = view_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_red_ff   <= RST_REF_RED;
         ref_green_ff <= RST_REF_GREEN;
         ref_blue_ff  <= RST_REF_BLUE;
         limit_ff     <= RST_MATCH_LIMIT;
         view_ff      <= RST_VIEW_ANGLE;
         width_ff     <= WID_W'(RST_W);
         height_ff    <= HGT_W'(RST_H);
         col_ff       <= '0;
         row_ff       <= '0;
         sum_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         ref_red_ff   <= ref_red_in;
         ref_green_ff <= ref_green_in;
         ref_blue_ff  <= ref_blue_in;
         limit_ff     <= limit_in;
         view_ff      <= view_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/clca_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module clca_queue #(
   parameter int DATA_W = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      pop_data,
   output logic                   full,
   output logic                   empty
);
   import clca_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_push, do_pop;

   assign full     = (fill_ff == FILL_W'(QUEUE_DEPTH));
   assign empty    = (fill_ff == '0);
   assign pop_data = slot_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   // Advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FILL_W'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/clca_back.sv =====
// Back end: centroid angle computation with an iterative divider and output register.
`default_nettype none

module clca_back #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024,
   localparam int COL_W = $clog2(MAX_WIDTH),
   localparam int WID_W = $clog2(MAX_WIDTH + 1),
   localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1),
   localparam int SUM_W = CNT_W + COL_W
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           job_ready,
   input  wire logic [SUM_W-1:0]               job_sum,
   input  wire logic [CNT_W-1:0]               job_count,
   input  wire logic [WID_W-1:0]               job_width,
   input  wire logic [clca_pkg::VIEW_W-1:0]    job_view,
   output logic                                job_pop,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_found,
   output logic signed [clca_pkg::ANGLE_W-1:0] rsp_line_angle
);
   import clca_pkg::*;

   localparam int CW_W  = CNT_W + WID_W;
   localparam int EXT_W = CW_W + 1;
   localparam int N_W   = CW_W + QUOT_W;

   back_state_type state_ff, state_in;
   back_ctrl_type  ctrl;

   logic [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [WID_W-1:0]  width_ff;
   logic [VIEW_W-1:0] view_ff;
   logic              found_ff;
   logic [CW_W-1:0]   cw_ff;
   logic [CW_W-1:0]   mag_ff;
   logic              neg_ff;
   logic [N_W-1:0]    rem_ff, rem_in;
   logic [N_W-1:0]    dsr_ff, dsr_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic              out_valid_ff, out_valid_in;
   logic              out_found_ff;
   logic [ANGLE_W-1:0] out_angle_ff;

   logic              out_free;
   logic              div_last;
   logic [EXT_W-1:0]  two_sum, cw_ext;
   logic [ANGLE_W-1:0] angle;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign div_last = (step_ff == STEP_W'(QUOT_W - 1));

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:    if (job_ready) state_in = BK_SCALE;
         BK_SCALE:   state_in = BK_OFFSET;
         BK_OFFSET:  state_in = BK_PRODUCT;
         BK_PRODUCT: state_in = BK_DIVIDE;
         BK_DIVIDE:  if (div_last) state_in = BK_DELIVER;
         BK_DELIVER: if (out_free) state_in = BK_IDLE;
         default:    state_in = BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      ctrl = '0;
      case (state_ff)
         BK_IDLE: begin
            ctrl.pop      = job_ready;
            ctrl.load_job = job_ready;
         end
         BK_DIVIDE:  ctrl.div_step = 1'b1;
         BK_DELIVER: ctrl.load_out = out_free;
         default: begin
         end
      endcase
   end

   assign job_pop = ctrl.pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Capture the job
   always_ff @(posedge clock) begin
      if (ctrl.load_job) begin
         sum_ff   <= job_sum;
         cnt_ff   <= job_count;
         width_ff <= job_width;
         view_ff  <= job_view;
         found_ff <= (job_count != '0);
      end
   end

   // Scale: count times width
   always_ff @(posedge clock) begin
      if (state_ff == BK_SCALE) begin
         cw_ff <= CW_W'(cnt_ff) * CW_W'(width_ff);
      end
   end

   // Offset: magnitude and sign of twice the sum minus count times width
   assign two_sum = EXT_W'({sum_ff, 1'b0});
   assign cw_ext  = EXT_W'(cw_ff);

   always_ff @(posedge clock) begin
      if (state_ff == BK_OFFSET) begin
         if (two_sum >= cw_ext) begin
            mag_ff <= CW_W'(two_sum - cw_ext);
            neg_ff <= 1'b0;
         end else begin
            mag_ff <= CW_W'(cw_ext - two_sum);
            neg_ff <= 1'b1;
         end
      end
   end

   // Product and restoring divide by twice count times width
   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      if (state_ff == BK_PRODUCT) begin
         rem_in  = N_W'(mag_ff) * N_W'(view_ff);
         dsr_in  = N_W'({cw_ff, 1'b0}) << (QUOT_W - 1);
         quo_in  = '0;
         step_in = '0;
      end else if (ctrl.div_step) begin
         if (rem_ff >= dsr_ff) begin
            rem_in = rem_ff - dsr_ff;
            quo_in = {quo_ff[QUOT_W-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QUOT_W-2:0], 1'b0};
         end
         dsr_in  = dsr_ff >> 1;
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   // Apply the sign; an empty frame gives zero
   always_comb begin
      if (!found_ff) begin
         angle = '0;
      end else if (neg_ff) begin
         angle = ANGLE_W'(-quo_ff);
      end else begin
         angle = ANGLE_W'(quo_ff);
      end
   end

   // Hold the result until it is taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctrl.load_out) begin
         out_valid_in = 1'b1;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_out) begin
         out_found_ff <= found_ff;
         out_angle_ff <= angle;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_found      = out_found_ff;
   assign rsp_line_angle = signed'(out_angle_ff);

endmodule

`default_nettype wire

// ===== rtl/core/color_line_centroid_angle.sv =====
// Throughput: one pixel request per cycle while the job queue is not full; a 2-entry job queue
//   feeds the back end, which works on one frame at a time with its 15-step restoring divider.
// Reset: synchronous, active high; registers return to their default values and the
//   frame position, sums and queue are cleared. No clearing pass is needed.
`default_nettype none

module color_line_centroid_angle #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_red,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_green,
   input  wire logic [clca_pkg::COLOR_W-1:0]      req_blue,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic signed [clca_pkg::ANGLE_W-1:0]    rsp_line_angle,
   input  wire logic                              csr_write,
   input  wire logic [clca_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [clca_pkg::CSR_DATA_W-1:0]   csr_data
);
   import clca_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WID_W  = $clog2(MAX_WIDTH + 1);
   localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
   localparam int SUM_W  = CNT_W + COL_W;
   localparam int DATA_W = SUM_W + CNT_W + WID_W + VIEW_W;

   logic              job_push, job_full, job_empty, job_pop;
   logic [SUM_W-1:0]  push_sum, pop_sum;
   logic [CNT_W-1:0]  push_count, pop_count;
   logic [WID_W-1:0]  push_width, pop_width;
   logic [VIEW_W-1:0] push_view, pop_view;
   logic [DATA_W-1:0] push_data, pop_data;

   clca_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .req_stall (req_stall),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .job_full  (job_full),
      .job_push  (job_push),
      .job_sum   (push_sum),
      .job_count (push_count),
      .job_width (push_width),
      .job_view  (push_view)
   );

   // Pack and unpack the queued job
   assign push_data = {push_sum, push_count, push_width, push_view};
   assign {pop_sum, pop_count, pop_width, pop_view} = pop_data;

   clca_queue #(
      .DATA_W (DATA_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (push_data),
      .pop       (job_pop),
      .pop_data  (pop_data),
      .full      (job_full),
      .empty     (job_empty)
   );

   clca_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_ready      (!job_empty),
      .job_sum        (pop_sum),
      .job_count      (pop_count),
      .job_width      (pop_width),
      .job_view       (pop_view),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_line_angle (rsp_line_angle)
   );

endmodule

`default_nettype wire

// ===== sim/tb_color_line_centroid_angle.sv =====
// Self-checking testbench for the color line centroid angle block.
`timescale 1ns / 1ps

module tb_color_line_centroid_angle;
   import clca_pkg::*;

   localparam int MAX_W         = 1024;
   localparam int MAX_H         = 1024;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int COLOR_MAX     = 2**COLOR_W - 1;
   localparam longint ANGLE_MAX = 2**(ANGLE_W-1) - 1;
   localparam longint ANGLE_MIN = -(2**(ANGLE_W-1));
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REGISTER = 3'd7;

   typedef struct packed {
      logic                      found;
      logic signed [ANGLE_W-1:0] angle;
   } frame_result_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [COLOR_W-1:0]              req_red;
   logic [COLOR_W-1:0]              req_green;
   logic [COLOR_W-1:0]              req_blue;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic                            rsp_found;
   logic signed [ANGLE_W-1:0]       rsp_line_angle;
   logic                            csr_write;
   logic [CSR_INDEX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]           csr_data;

   // Centroid predictor: register copies and frame accumulators
   logic [COLOR_W-1:0] model_red, model_green, model_blue;
   logic [LIMIT_W-1:0] model_limit;
   logic [SIZE_W-1:0]  model_width, model_height;
   logic [VIEW_W-1:0]  model_view;
   int                 model_column;
   int                 model_left;
   longint             model_sum;
   longint             model_hits;

   frame_result_type pending_angles[$];
   frame_result_type due_result;

   int send_gap_pct = 27;
   int stall_pct    = 49;
   int mismatch_count;
   int results_checked;
   int pixels_sent;
   int frames_found;
   int frames_empty;
   int reg_writes;
   int cycle_count;

   color_line_centroid_angle uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_found      (rsp_found),
      .rsp_line_angle (rsp_line_angle),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_count, pending_angles.size());
      $display("Simulation FAILED");
      $finish;
   end

   // Throttle the result side at random
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic int clamp_size(input logic [SIZE_W-1:0] raw, input int cap);
      if (raw == 0) return 1;
      if (int'(raw) > cap) return cap;
      return int'(raw);
   endfunction

   function automatic int color_gap(input logic [COLOR_W-1:0] a,
                                    input logic [COLOR_W-1:0] b);
      return (a > b) ? int'(a) - int'(b) : int'(b) - int'(a);
   endfunction

   function automatic logic [COLOR_W-1:0] near_value(input logic [COLOR_W-1:0] center);
      int v;
      v = int'(center) + int'($urandom_range(24)) - 12;
      if (v < 0) v = 0;
      if (v > COLOR_MAX) v = COLOR_MAX;
      return v[COLOR_W-1:0];
   endfunction

   // Clear the accumulators and reload the pixel counter for the current size
   task restart_frame();
      model_column = 0;
      model_sum    = 0;
      model_hits   = 0;
      model_left   = clamp_size(model_width, MAX_W) * clamp_size(model_height, MAX_H) - 1;
   endtask

   task load_defaults();
      model_red    = RST_REF_RED;
      model_green  = RST_REF_GREEN;
      model_blue   = RST_REF_BLUE;
      model_limit  = RST_MATCH_LIMIT;
      model_width  = RST_FRAME_SIZE;
      model_height = RST_FRAME_SIZE;
      model_view   = RST_VIEW_ANGLE;
      restart_frame();
   endtask

   task apply_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      case (idx)
         CSR_REF_RED:     model_red   = data[COLOR_W-1:0];
         CSR_REF_GREEN:   model_green = data[COLOR_W-1:0];
         CSR_REF_BLUE:    model_blue  = data[COLOR_W-1:0];
         CSR_MATCH_LIMIT: model_limit = data[LIMIT_W-1:0];
         CSR_FRAME_WIDTH: begin
            model_width = data[SIZE_W-1:0];
            restart_frame();
         end
         CSR_FRAME_HEIGHT: begin
            model_height = data[SIZE_W-1:0];
            restart_frame();
         end
         CSR_VIEW_ANGLE:  model_view  = data[VIEW_W-1:0];
         default: ;
      endcase
   endtask

   // Accumulate one pixel; on the last pixel of a frame queue the expected angle
   task predict_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                      input logic [COLOR_W-1:0] b);
      int               w;
      int               color_dist;
      longint           cw;
      longint           num;
      longint           ang;
      frame_result_type res;
      w          = clamp_size(model_width, MAX_W);
      color_dist = color_gap(r, model_red) + color_gap(g, model_green)
                 + color_gap(b, model_blue);
      if (color_dist < int'(model_limit)) begin
         model_sum += model_column;
         model_hits++;
      end
      if (model_column + 1 >= w) model_column = 0;
      else model_column++;
      if (model_left != 0) begin
         model_left--;
      end else begin
         if (model_hits == 0) begin
            res.found = 1'b0;
            res.angle = '0;
            frames_empty++;
         end else begin
            cw  = model_hits * w;
            num = (2 * model_sum - cw) * longint'(model_view);
            ang = num / (2 * cw);
            if (ang > ANGLE_MAX) ang = ANGLE_MAX;
            if (ang < ANGLE_MIN) ang = ANGLE_MIN;
            res.found = 1'b1;
            res.angle = ang[ANGLE_W-1:0];
            frames_found++;
         end
         pending_angles.push_back(res);
         restart_frame();
      end
   endtask

   // Compare each accepted result with the oldest pending frame
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_angles.size() == 0) begin
            report_mismatch($sformatf("result with no frame pending (found %0b angle %0d)",
                                      rsp_found, rsp_line_angle));
         end else begin
            due_result = pending_angles.pop_front();
            if (rsp_found !== due_result.found)
               report_mismatch($sformatf("frame %0d found got %0b expected %0b",
                                         results_checked, rsp_found, due_result.found));
            if (rsp_line_angle !== due_result.angle)
               report_mismatch($sformatf("frame %0d line_angle got %0d expected %0d",
                                         results_checked, rsp_line_angle, due_result.angle));
            results_checked++;
         end
      end
   end

   // Hold one pixel request until accepted, with random gaps ahead of it
   task send_pixel(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                   input logic [COLOR_W-1:0] b);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_pixel(r, g, b);
      pixels_sent++;
      @(negedge clock);
   endtask

   // Half the pixels sit near the reference color, the rest anywhere
   task send_line_pixel();
      if ($urandom_range(1))
         send_pixel(near_value(model_red), near_value(model_green), near_value(model_blue));
      else
         send_pixel(COLOR_W'($urandom_range(COLOR_MAX)), COLOR_W'($urandom_range(COLOR_MAX)),
                    COLOR_W'($urandom_range(COLOR_MAX)));
   endtask

   task write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      apply_reg(idx, data);
      reg_writes++;
      @(negedge clock);
      csr_write <= 1'b0;
      @(negedge clock);
   endtask

   // Drop valid, drain pending frames and let the pipeline empty
   task settle_block();
      req_valid <= 1'b0;
      while (pending_angles.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // Small frames at the power-up color, threshold and field of view
   task test_reset_values();
      write_reg(CSR_FRAME_WIDTH, 15'd8);
      write_reg(CSR_FRAME_HEIGHT, 15'd2);
      repeat (32) send_line_pixel();
      settle_block();
   endtask

   // Single-pixel frames around the match threshold and color extremes
   task test_match_limit();
      write_reg(CSR_FRAME_WIDTH, 15'h7800);
      write_reg(CSR_FRAME_HEIGHT, 15'h7800);
      write_reg(CSR_VIEW_ANGLE, 15'h7FFF);
      write_reg(CSR_REF_RED, 15'h7FFF);
      write_reg(CSR_REF_GREEN, 15'h7F00);
      write_reg(CSR_REF_BLUE, 15'h00FF);
      write_reg(CSR_MATCH_LIMIT, 15'd766);
      send_pixel(8'd0, 8'd255, 8'd0);
      settle_block();
      write_reg(CSR_MATCH_LIMIT, 15'd765);
      send_pixel(8'd0, 8'd255, 8'd0);
      settle_block();
      write_reg(CSR_MATCH_LIMIT, 15'h7FFF);
      send_pixel(8'd0, 8'd255, 8'd0);
      settle_block();
      write_reg(CSR_MATCH_LIMIT, 15'd0);
      send_pixel(8'd255, 8'd0, 8'd255);
      settle_block();
      write_reg(CSR_MATCH_LIMIT, 15'd1);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_pixel(8'd254, 8'd0, 8'd255);
      settle_block();
   endtask

   // Register writes in the middle of a frame, ignored index, zero field of view
   task test_midframe_writes();
      write_reg(CSR_FRAME_WIDTH, 15'd3);
      write_reg(CSR_FRAME_HEIGHT, 15'd2);
      write_reg(CSR_MATCH_LIMIT, 15'd60);
      write_reg(CSR_VIEW_ANGLE, 15'd4096);
      write_reg(CSR_REF_RED, 15'd100);
      write_reg(CSR_REF_GREEN, 15'd150);
      write_reg(CSR_REF_BLUE, 15'd200);
      repeat (4) send_line_pixel();
      settle_block();
      write_reg(CSR_REF_RED, 15'd30);
      write_reg(CSR_MATCH_LIMIT, 15'd200);
      write_reg(CSR_VIEW_ANGLE, 15'd12000);
      repeat (2) send_line_pixel();
      settle_block();
      // a size write abandons the partial frame
      repeat (3) send_line_pixel();
      settle_block();
      write_reg(CSR_FRAME_WIDTH, 15'd2);
      repeat (4) send_line_pixel();
      settle_block();
      write_reg(CSR_NO_REGISTER, 15'h7FFF);
      repeat (4) send_line_pixel();
      settle_block();
      write_reg(CSR_VIEW_ANGLE, 15'd0);
      repeat (4) send_line_pixel();
      settle_block();
   endtask

   function automatic logic [COLOR_W-1:0] pick_color();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? COLOR_W'(COLOR_MAX) : '0;
      return COLOR_W'($urandom_range(COLOR_MAX));
   endfunction

   function automatic logic [LIMIT_W-1:0] pick_limit();
      case ($urandom_range(7))
         0:       return '0;
         1:       return LIMIT_W'(765 + $urandom_range(1));
         2:       return LIMIT_W'($urandom_range(766, 1023));
         default: return LIMIT_W'($urandom_range(8, 90));
      endcase
   endfunction

   // New reference, threshold and view; usually a new small size as well
   task randomize_settings();
      logic [CSR_DATA_W-1:0] data;
      data = CSR_DATA_W'($urandom());
      data[COLOR_W-1:0] = pick_color();
      write_reg(CSR_REF_RED, data);
      data = CSR_DATA_W'($urandom());
      data[COLOR_W-1:0] = pick_color();
      write_reg(CSR_REF_GREEN, data);
      data = CSR_DATA_W'($urandom());
      data[COLOR_W-1:0] = pick_color();
      write_reg(CSR_REF_BLUE, data);
      data = CSR_DATA_W'($urandom());
      data[LIMIT_W-1:0] = pick_limit();
      write_reg(CSR_MATCH_LIMIT, data);
      if ($urandom_range(7) == 0) data = $urandom_range(1) ? '1 : '0;
      else data = CSR_DATA_W'($urandom());
      write_reg(CSR_VIEW_ANGLE, data);
      if ($urandom_range(3) != 0) begin
         data = CSR_DATA_W'($urandom());
         data[SIZE_W-1:0] = SIZE_W'($urandom_range(9));
         write_reg(CSR_FRAME_WIDTH, data);
         data = CSR_DATA_W'($urandom());
         data[SIZE_W-1:0] = SIZE_W'($urandom_range(5));
         write_reg(CSR_FRAME_HEIGHT, data);
      end
      if ($urandom_range(7) == 0) write_reg(CSR_NO_REGISTER, CSR_DATA_W'($urandom()));
   endtask

   // Random settings, then whole frames and sometimes a partial one
   task run_random_frames(input int budget);
      int target;
      int per_frame;
      int count;
      target = pixels_sent + budget;
      while (pixels_sent < target) begin
         settle_block();
         randomize_settings();
         per_frame = clamp_size(model_width, MAX_W) * clamp_size(model_height, MAX_H);
         count = per_frame * $urandom_range(1, 3);
         if ($urandom_range(3) == 0) count += $urandom_range(1, per_frame);
         repeat (count) send_line_pixel();
      end
      settle_block();
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      csr_write <= 1'b0;
      csr_index <= CSR_REF_RED;
      csr_data  <= '0;
      load_defaults();
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_values();
      test_match_limit();
      test_midframe_writes();
      run_random_frames(240);

      send_gap_pct = 49;
      stall_pct    = 27;
      run_random_frames(235);

      send_gap_pct = 0;
      stall_pct    = 0;
      run_random_frames(235);

      $display("Sent %0d pixels and checked %0d frame angles (%0d with a line, %0d without)",
               pixels_sent, results_checked, frames_found, frames_empty);
      $display("Applied %0d register writes, among them mid-frame, zero-size and unused-index",
               reg_writes);
      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
